@@ design/pffe_pkg.sv @@
// Package for the palette fast fade engine: input codes, sweep control types,
// controller/datapath command and status structs, channel step functions.
// No dependencies.
package pffe_pkg;

  // input word kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // fade submodes
  localparam logic [1:0] SUB_IN_WHITE  = 2'd0;
  localparam logic [1:0] SUB_OUT_WHITE = 2'd1;
  localparam logic [1:0] SUB_IN_BLACK  = 2'd2;
  localparam logic [1:0] SUB_OUT_BLACK = 2'd3;

  localparam logic [4:0]  LEVEL_START = 5'd31;
  localparam logic [4:0]  LEVEL_STEP  = 5'd2;
  localparam logic [4:0]  CHAN_MAX    = 5'd31;
  localparam logic [2:0]  FINISH_LAST = 3'd4;
  localparam logic [15:0] WHITE_WORD  = 16'h7FFF;
  localparam logic [15:0] FULL_WORD   = 16'hFFFF;

  // which part of the palette a sweep covers
  typedef enum logic [1:0] {
    SEL_ALL  = 2'd0,
    SEL_LOW  = 2'd1,
    SEL_HIGH = 2'd2
  } sweep_sel_e;

  // what a sweep writes into the display store
  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_STEP  = 2'd2
  } sweep_mode_e;

  typedef struct packed {
    logic        load;      // write both stores at the input index
    logic        rd_req;    // read display store at the input index
    logic        grab;      // capture read data into the result word
    logic        clr_res;   // result word is zero
    logic        go;        // start a sweep
    sweep_sel_e  sel;
    sweep_mode_e mode;
    logic [15:0] fill;
    logic [1:0]  kind;      // fade submode used by a step sweep
    logic        out_load;  // move result into the output register
    logic        active;
    logic [4:0]  level;
  } cmd_t;

  typedef struct packed {
    logic busy;             // sweep issuing or writing
  } sts_t;

  function automatic logic [4:0] step_chan(logic [4:0] cur, logic [4:0] src,
                                           logic [1:0] kind);
    logic [5:0] up;
    logic [4:0] dn;
    logic [4:0] res;
    up = {1'b0, cur} + {1'b0, LEVEL_STEP};
    dn = (cur >= LEVEL_STEP) ? cur - LEVEL_STEP : 5'd0;
    unique case (kind)
      SUB_IN_WHITE:  res = (dn < src) ? src : dn;
      SUB_OUT_WHITE: res = (up > {1'b0, CHAN_MAX}) ? CHAN_MAX : up[4:0];
      SUB_IN_BLACK:  res = (up > {1'b0, src}) ? src : up[4:0];
      default:       res = dn;
    endcase
    return res;
  endfunction

  // bit 15 always cleared by a step
  function automatic logic [15:0] step_word(logic [15:0] cur, logic [15:0] src,
                                            logic [1:0] kind);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    r = step_chan(cur[4:0], src[4:0], kind);
    g = step_chan(cur[9:5], src[9:5], kind);
    b = step_chan(cur[14:10], src[14:10], kind);
    return {1'b0, b, g, r};
  endfunction

endpackage

@@ design/palette_fast_fade_engine_unit.sv @@
// Load, read and a tick without a walk run no sweep; a tick with a walk sweeps
// half of the palette, and the whole palette again when the level reaches 0; a
// fade-in start adds a fill of the whole palette. Throughput: the next word is
// taken once the controller is back in idle after a result is registered; the
// display store port (one entry per cycle) sets the walk and fill lengths.
// Reset clears the fade state and output valid; palettes stay undefined until loaded.
module palette_fast_fade_engine_unit #(
  parameter int PALETTE_ENTRIES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [8:0]  index_i,
  input  logic [15:0] color_i,
  input  logic [1:0]  submode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_color_o,
  output logic        fade_active_o,
  output logic [4:0]  fade_level_o
);

  // controller sequences each word: load, read, start (optional fill sweep),
  // tick (half walk, then final sweep when the level hits zero)
  pffe_pkg::cmd_t cmd;
  pffe_pkg::sts_t sts;

  pffe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .submode_i   (submode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath holds both stores and the output word register, which keeps
  // a finished result while the next word is already being taken in
  pffe_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .index_i       (index_i),
    .color_i       (color_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .read_color_o  (read_color_o),
    .fade_active_o (fade_active_o),
    .fade_level_o  (fade_level_o)
  );

endmodule

@@ design/pffe_dp.sv @@
// Datapath of the palette fast fade engine: source and display stores,
// sweep address generator with a one-stage read/write pipeline, result regs.
// Depends on pffe_pkg.
module pffe_dp #(
  parameter int PALETTE_ENTRIES = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [8:0]      index_i,
  input  logic [15:0]     color_i,
  input  pffe_pkg::cmd_t  cmd_i,
  output pffe_pkg::sts_t  sts_o,
  output logic [15:0]     read_color_o,
  output logic            fade_active_o,
  output logic [4:0]      fade_level_o
);

  localparam int AW   = $clog2(PALETTE_ENTRIES);
  localparam int IXW  = ((AW > 9) ? AW : 9) + 1;
  localparam int HALF = PALETTE_ENTRIES / 2;

  logic [15:0] src_mem [PALETTE_ENTRIES];
  logic [15:0] dsp_mem [PALETTE_ENTRIES];

  logic [IXW-1:0] idx_ext;
  logic           idx_ok;
  logic [AW-1:0]  idx_addr;
  logic [AW-1:0]  rd_addr;

  logic [AW-1:0]         sw_addr_q, sw_addr_d;
  logic [AW:0]           sw_rem_q, sw_rem_d;
  pffe_pkg::sweep_mode_e sw_mode_q;
  logic [15:0]           sw_fill_q;
  logic [1:0]            sw_kind_q;
  logic                  s1_v_q;
  logic [AW-1:0]         s1_addr_q;

  logic [15:0] src_rd_q, dsp_rd_q;
  logic [15:0] wdata;
  logic        rd_ok_q;
  logic [15:0] res_word_q;
  logic [15:0] read_color_q;
  logic        active_q;
  logic [4:0]  level_q;

  assign idx_ext  = IXW'(index_i);
  assign idx_ok   = idx_ext < IXW'(PALETTE_ENTRIES);
  assign idx_addr = idx_ext[AW-1:0];

  assign rd_addr  = (sw_rem_q != '0) ? sw_addr_q : idx_addr;

  always_comb begin
    sw_addr_d = sw_addr_q;
    sw_rem_d  = sw_rem_q;
    if (cmd_i.go) begin
      unique case (cmd_i.sel)
        pffe_pkg::SEL_LOW: begin
          sw_addr_d = '0;
          sw_rem_d  = (AW+1)'(HALF);
        end
        pffe_pkg::SEL_HIGH: begin
          sw_addr_d = AW'(HALF);
          sw_rem_d  = (AW+1)'(PALETTE_ENTRIES - HALF);
        end
        default: begin
          sw_addr_d = '0;
          sw_rem_d  = (AW+1)'(PALETTE_ENTRIES);
        end
      endcase
    end else if (sw_rem_q != '0) begin
      sw_addr_d = sw_addr_q + AW'(1);
      sw_rem_d  = sw_rem_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_rem_q <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      sw_rem_q <= sw_rem_d;
      s1_v_q   <= (sw_rem_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q <= sw_addr_d;
    s1_addr_q <= sw_addr_q;
    if (cmd_i.go) begin
      sw_mode_q <= cmd_i.mode;
      sw_fill_q <= cmd_i.fill;
      sw_kind_q <= cmd_i.kind;
    end
  end

  always_comb begin
    unique case (sw_mode_q)
      pffe_pkg::MODE_COPY: wdata = src_rd_q;
      pffe_pkg::MODE_STEP: wdata = pffe_pkg::step_word(dsp_rd_q, src_rd_q, sw_kind_q);
      default:             wdata = sw_fill_q;
    endcase
  end

  // stores: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    src_rd_q <= src_mem[rd_addr];
    dsp_rd_q <= dsp_mem[rd_addr];
    if (cmd_i.load && idx_ok) begin
      src_mem[idx_addr] <= color_i;
    end
    if (s1_v_q) begin
      dsp_mem[s1_addr_q] <= wdata;
    end else if (cmd_i.load && idx_ok) begin
      dsp_mem[idx_addr] <= color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_req) begin
      rd_ok_q <= idx_ok;
    end
    if (cmd_i.clr_res) begin
      res_word_q <= '0;
    end else if (cmd_i.grab) begin
      res_word_q <= rd_ok_q ? dsp_rd_q : 16'd0;
    end
    if (cmd_i.out_load) begin
      read_color_q <= res_word_q;
      active_q     <= cmd_i.active;
      level_q      <= cmd_i.level;
    end
  end

  assign sts_o.busy    = (sw_rem_q != '0) || s1_v_q;
  assign read_color_o  = read_color_q;
  assign fade_active_o = active_q;
  assign fade_level_o  = level_q;

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go |-> !sts_o.busy)
    else $error("sweep started while another runs");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !s1_v_q)
    else $error("load collides with sweep write");

endmodule

@@ design/pffe_ctrl.sv @@
// Controller of the palette fast fade engine: word sequencing state machine,
// fade state registers and output valid flag. Depends on pffe_pkg.
module pffe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  logic [1:0]     submode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pffe_pkg::cmd_t cmd_o,
  input  pffe_pkg::sts_t sts_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDW   = 7'b0000010,
    S_FILLW = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_WALKW = 7'b0010000,
    S_FINW  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] level_q, level_d;
  logic       half_q, half_d;
  logic [1:0] kind_q, kind_d;
  logic       running_q, running_d;
  logic       fast_q, fast_d;
  logic       finishing_q, finishing_d;
  logic [2:0] fin_cnt_q, fin_cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [4:0] level_dec;

  assign level_dec = (level_q >= pffe_pkg::LEVEL_STEP) ?
                     level_q - pffe_pkg::LEVEL_STEP : 5'd0;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    half_d      = half_q;
    kind_d      = kind_q;
    running_d   = running_q;
    fast_d      = fast_q;
    finishing_d = finishing_q;
    fin_cnt_d   = fin_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o          = '0;
    cmd_o.sel      = pffe_pkg::SEL_ALL;
    cmd_o.mode     = pffe_pkg::MODE_CONST;
    cmd_o.kind     = kind_q;
    cmd_o.active   = running_q;
    cmd_o.level    = level_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            pffe_pkg::KIND_LOAD: begin
              cmd_o.load    = 1'b1;
              cmd_o.clr_res = 1'b1;
              state_d       = S_OUT;
            end
            pffe_pkg::KIND_READ: begin
              cmd_o.rd_req = 1'b1;
              state_d      = S_RDW;
            end
            pffe_pkg::KIND_START: begin
              cmd_o.clr_res = 1'b1;
              level_d       = pffe_pkg::LEVEL_START;
              kind_d        = submode_i;
              running_d     = 1'b1;
              fast_d        = 1'b1;
              if (submode_i == pffe_pkg::SUB_IN_WHITE ||
                  submode_i == pffe_pkg::SUB_IN_BLACK) begin
                cmd_o.go   = 1'b1;
                cmd_o.fill = (submode_i == pffe_pkg::SUB_IN_WHITE) ?
                             pffe_pkg::WHITE_WORD : 16'd0;
                state_d    = S_FILLW;
              end else begin
                state_d = S_UPD;
              end
            end
            default: begin
              cmd_o.clr_res = 1'b1;
              state_d       = S_UPD;
            end
          endcase
        end
      end
      S_RDW: begin
        cmd_o.grab = 1'b1;
        state_d    = S_OUT;
      end
      S_FILLW: begin
        if (!sts_i.busy) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        priority if (!running_q) begin
          state_d = S_OUT;
        end else if (finishing_q) begin
          if (fin_cnt_q == pffe_pkg::FINISH_LAST) begin
            running_d   = 1'b0;
            finishing_d = 1'b0;
            fin_cnt_d   = '0;
          end else begin
            fin_cnt_d = fin_cnt_q + 3'd1;
          end
          state_d = S_OUT;
        end else if (!fast_q) begin
          state_d = S_OUT;
        end else begin
          cmd_o.go   = 1'b1;
          cmd_o.sel  = half_q ? pffe_pkg::SEL_HIGH : pffe_pkg::SEL_LOW;
          cmd_o.mode = pffe_pkg::MODE_STEP;
          state_d    = S_WALKW;
        end
      end
      S_WALKW: begin
        if (!sts_i.busy) begin
          half_d  = !half_q;
          state_d = S_OUT;
          if (half_q) begin
            level_d = level_dec;
            if (level_dec == 5'd0) begin
              fast_d      = 1'b0;
              finishing_d = 1'b1;
              cmd_o.go    = 1'b1;
              if (kind_q == pffe_pkg::SUB_IN_WHITE ||
                  kind_q == pffe_pkg::SUB_IN_BLACK) begin
                cmd_o.mode = pffe_pkg::MODE_COPY;
              end
              cmd_o.fill = (kind_q == pffe_pkg::SUB_OUT_WHITE) ?
                           pffe_pkg::FULL_WORD : 16'd0;
              state_d    = S_FINW;
            end
          end
        end
      end
      S_FINW: begin
        if (!sts_i.busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      half_q      <= 1'b0;
      kind_q      <= '0;
      running_q   <= 1'b0;
      fast_q      <= 1'b0;
      finishing_q <= 1'b0;
      fin_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      half_q      <= half_d;
      kind_q      <= kind_d;
      running_q   <= running_d;
      fast_q      <= fast_d;
      finishing_q <= finishing_d;
      fin_cnt_q   <= fin_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_fast_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fast_q |-> (level_q != 5'd0))
    else $error("fast mode with level zero");

  a_fin_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finishing_q |-> (fin_cnt_q == 3'd0))
    else $error("finish count moved outside finishing phase");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.busy)
    else $error("datapath sweep still running while idle");

endmodule

@@ bench/palette_fast_fade_engine_unit_tb.sv @@
// Self-checking bench for palette_fast_fade_engine_unit: drives load, start,
// tick and read words with random gaps and output stalls, checks every result.
// Depends on pffe_pkg (input kinds, submodes, fade constants) and the DUT.
module palette_fast_fade_engine_unit_tb;
  import pffe_pkg::*;

  localparam int N_ENTRIES    = 512;
  localparam int ITEM_TARGET  = 1200;
  // a fade-in start costs fill + walk, a last tick walk + final fill
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 1200;

  // one result word as the DUT presents it
  typedef struct packed {
    logic [15:0] color;
    logic        active;
    logic [4:0]  level;
  } fade_word_t;

  // Mirrors the fade engine: both palettes, level, half pointer, finishing
  // counter. Each accepted input word pushes one expected result word.
  class fade_scoreboard;
    int          entries;
    logic [15:0] src_pal [];
    logic [15:0] disp_pal [];
    logic [4:0]  level;
    logic        upper_half;
    logic [1:0]  sub_kind;
    logic        running;
    logic        fast_mode;
    logic        finishing;
    logic [2:0]  finish_cnt;
    fade_word_t  expected_q [$];
    int          fails;

    function new(int n);
      entries    = n;
      src_pal    = new[n];
      disp_pal   = new[n];
      level      = '0;
      upper_half = 1'b0;
      sub_kind   = SUB_IN_WHITE;
      running    = 1'b0;
      fast_mode  = 1'b0;
      finishing  = 1'b0;
      finish_cnt = '0;
      fails      = 0;
    endfunction

    // one 5-bit channel moved by the step toward its target
    function logic [4:0] chan_next(logic [4:0] cur, logic [4:0] src);
      int up;
      int dn;
      up = int'(cur) + int'(LEVEL_STEP);
      dn = (cur >= LEVEL_STEP) ? int'(cur) - int'(LEVEL_STEP) : 0;
      case (sub_kind)
        SUB_IN_WHITE:  return (dn < int'(src)) ? src : 5'(dn);
        SUB_OUT_WHITE: return (up > int'(CHAN_MAX)) ? CHAN_MAX : 5'(up);
        SUB_IN_BLACK:  return (up > int'(src)) ? src : 5'(up);
        default:       return 5'(dn);
      endcase
    endfunction

    function void tick_fade();
      int          lo;
      logic [15:0] cur;
      logic [15:0] src;
      if (!running) return;
      // finishing phase wins over stepping
      if (finishing) begin
        if (finish_cnt == FINISH_LAST) begin
          running    = 1'b0;
          finishing  = 1'b0;
          finish_cnt = '0;
        end else begin
          finish_cnt = finish_cnt + 3'd1;
        end
        return;
      end
      if (!fast_mode) return;
      lo = upper_half ? entries / 2 : 0;
      for (int i = lo; i < lo + entries / 2; i++) begin
        cur = disp_pal[i];
        src = src_pal[i];
        disp_pal[i] = {1'b0, chan_next(cur[14:10], src[14:10]),
                       chan_next(cur[9:5], src[9:5]), chan_next(cur[4:0], src[4:0])};
      end
      upper_half = ~upper_half;
      if (upper_half) return;
      level = (level >= LEVEL_STEP) ? level - LEVEL_STEP : '0;
      if (level == '0) begin
        foreach (disp_pal[i]) begin
          case (sub_kind)
            SUB_IN_WHITE, SUB_IN_BLACK: disp_pal[i] = src_pal[i];
            SUB_OUT_WHITE:              disp_pal[i] = FULL_WORD;
            default:                    disp_pal[i] = '0;
          endcase
        end
        fast_mode = 1'b0;
        finishing = 1'b1;
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [8:0] idx, logic [15:0] color,
                             logic [1:0] sub);
      fade_word_t w;
      w.color = '0;
      case (kind)
        KIND_LOAD: begin
          if (idx < entries) begin
            src_pal[idx]  = color;
            disp_pal[idx] = color;
          end
        end
        KIND_START: begin
          // half pointer and finishing state survive a restart
          level     = LEVEL_START;
          sub_kind  = sub;
          running   = 1'b1;
          fast_mode = 1'b1;
          if (sub == SUB_IN_WHITE || sub == SUB_IN_BLACK) begin
            foreach (disp_pal[i]) disp_pal[i] = (sub == SUB_IN_WHITE) ? WHITE_WORD : '0;
          end
          tick_fade();
        end
        KIND_TICK: tick_fade();
        default: begin
          if (idx < entries) w.color = disp_pal[idx];
        end
      endcase
      w.active = running;
      w.level  = level;
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [15:0] color, logic active, logic [4:0] lvl);
      fade_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: read_color %h fade_active %b fade_level %0d",
               color, active, lvl);
        fails++;
        return;
      end
      w = expected_q.pop_front();
      if (color !== w.color) begin
        $error("read_color: expected %h, got %h", w.color, color);
        fails++;
      end
      if (active !== w.active) begin
        $error("fade_active: expected %b, got %b", w.active, active);
        fails++;
      end
      if (lvl !== w.level) begin
        $error("fade_level: expected %0d, got %0d", w.level, lvl);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i       = KIND_TICK;
  logic [8:0]  index_i      = '0;
  logic [15:0] color_i      = '0;
  logic [1:0]  submode_i    = SUB_IN_WHITE;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [15:0] read_color_o;
  logic        fade_active_o;
  logic [4:0]  fade_level_o;

  fade_scoreboard sb;
  bit             no_idle     = 1'b0;  // set for stretches without gaps or stalls
  int             n_sent      = 0;
  int             idle_cycles = 0;

  palette_fast_fade_engine_unit #(
    .PALETTE_ENTRIES(N_ENTRIES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .index_i      (index_i),
    .color_i      (color_i),
    .submode_i    (submode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_color_o (read_color_o),
    .fade_active_o(fade_active_o),
    .fade_level_o (fade_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a long run of cycles with no word moving on either side means
  // the DUT hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // colours lean on the extremes: all zero, all one, white, bit 15 alone
  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return WHITE_WORD;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one input word after a random gap and hold it until accepted.
  // Called at a rising edge; valid is dropped only when a gap follows, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic send_word(input logic [1:0] kind, input logic [8:0] idx,
                           input logic [15:0] color, input logic [1:0] sub);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    index_i    <= idx;
    color_i    <= color;
    submode_i  <= sub;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    sb.note_input(kind, idx, color, sub);
    n_sent++;
  endtask

  // Result side: random stall before each word, then hold ready until one
  // is taken. Values are sampled at the edge, before the DUT updates them.
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      sb.check_result(read_color_o, fade_active_o, fade_level_o);
    end
  end

  initial begin
    int n_ticks;
    int pick;
    sb = new(N_ENTRIES);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, then loads and reads at both ends of the palette
    send_word(KIND_TICK, 9'h1FF, 16'hFFFF, SUB_OUT_BLACK);
    send_word(KIND_LOAD, 9'd0, 16'hFFFF, SUB_IN_WHITE);
    send_word(KIND_READ, 9'd0, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_LOAD, 9'h1FF, 16'h0000, SUB_OUT_BLACK);
    send_word(KIND_READ, 9'h1FF, 16'hFFFF, SUB_OUT_BLACK);

    // every entry must hold a value before the first walk touches it
    for (int i = 1; i < N_ENTRIES - 1; i++) begin
      send_word(KIND_LOAD, 9'(i), rand_color(), 2'($urandom));
    end
    send_word(KIND_LOAD, 9'd256, 16'h8000, SUB_IN_BLACK);

    // each submode, a restart mid-fade, a load while fading
    send_word(KIND_START, 9'd0, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_READ, 9'd0, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_TICK, 9'd0, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_READ, 9'd255, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_TICK, 9'd0, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_READ, 9'd256, 16'h0000, SUB_IN_WHITE);
    send_word(KIND_START, 9'd0, 16'h0000, SUB_OUT_WHITE);
    send_word(KIND_TICK, 9'd0, 16'h0000, SUB_OUT_WHITE);
    send_word(KIND_READ, 9'h1FF, 16'h0000, SUB_OUT_WHITE);
    send_word(KIND_START, 9'd0, 16'h0000, SUB_IN_BLACK);
    send_word(KIND_TICK, 9'd0, 16'h0000, SUB_IN_BLACK);
    send_word(KIND_READ, 9'd256, 16'h0000, SUB_IN_BLACK);
    send_word(KIND_START, 9'd0, 16'h0000, SUB_OUT_BLACK);
    send_word(KIND_LOAD, 9'd5, WHITE_WORD, SUB_OUT_BLACK);
    send_word(KIND_TICK, 9'd0, 16'h0000, SUB_OUT_BLACK);
    send_word(KIND_READ, 9'd5, 16'h0000, SUB_OUT_BLACK);

    // Mostly whole fades (start, enough ticks to reach level 0 and run out
    // the finishing phase) with reads and loads mixed in; some fades cut
    // short by a restart, some bursts of arbitrary words.
    while (n_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send_word(KIND_START, 9'($urandom), rand_color(), 2'($urandom));
        n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(36, 40);
        repeat (n_ticks) begin
          pick = $urandom_range(0, 7);
          if (pick == 0) begin
            send_word(KIND_READ, 9'($urandom), rand_color(), 2'($urandom));
          end else if (pick == 1) begin
            send_word(KIND_LOAD, 9'($urandom), rand_color(), 2'($urandom));
          end
          send_word(KIND_TICK, 9'($urandom), rand_color(), 2'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_word(2'($urandom), 9'($urandom), rand_color(), 2'($urandom));
        end
      end
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;

    // drain, then leave room for any stray result word
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pffe_pkg.sv
design/pffe_dp.sv
design/pffe_ctrl.sv
design/palette_fast_fade_engine_unit.sv
bench/palette_fast_fade_engine_unit_tb.sv
